### rtl/hsv2rgb_pkg.sv
// Shared types and constants for the HSV to RGB conversion pipeline.
package hsv2rgb_pkg;

  localparam int unsigned NUM_W       = 22;
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 38;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  // ceil(2^38 / 15300): exact floor division for numerators below 2^22
  localparam logic [RECIP_W-1:0] RECIP = 25'd17965877;

  localparam logic [6:0] SECTOR_DEG = 7'd60;

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  typedef struct packed {
    logic [15:0] chroma;
    logic [15:0] vscale;
    logic [5:0]  ramp;
    sector_t     sector;
  } shade_t;

  typedef struct packed {
    logic [NUM_W-1:0] pc;
    logic [NUM_W-1:0] px;
    logic [NUM_W-1:0] off;
    sector_t          sector;
  } part_t;

  typedef struct packed {
    logic [NUM_W-1:0] nr;
    logic [NUM_W-1:0] ng;
    logic [NUM_W-1:0] nb;
  } numer_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

endpackage

### rtl/hsv_to_rgb_convert.sv
// Top level: HSV to RGB pixel converter, four-stage streaming pipeline.
//
// Slave channel (s_tvalid, s_tready, s_tdata) carries one pixel per beat:
// hue 0..359 in degrees, saturation and brightness 0..255 for 0..1.
// Master channel (m_tvalid, m_tready, m_tdata) returns one 8-bit RGB pixel
// per input beat, in order, each channel truncated toward zero.
// Each input beat passes through four register stages in order (sector
// decode, part scaling, sector routing, reciprocal divide by 15300);
// throughput is one pixel per cycle while the receiver does not stall.
// Hue values of 360 and above fall into the magenta-to-red sector.
// Each stage holds its own valid bit and takes a new beat whenever it is
// empty or its successor takes its beat, so bubbles close up.
// When the receiver stalls, the output register holds its beat and the
// stages fill one after another; s_tready drops only once all four hold
// data. Nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module hsv_to_rgb_convert
  import hsv2rgb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // hue[8:0], saturation[16:9], brightness[24:17], zero[31:25]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata   // red[7:0], green[15:8], blue[23:16]
);

  shade_t shade;
  logic   shade_valid;
  logic   shade_ready;
  part_t  part;
  logic   part_valid;
  logic   part_ready;
  numer_t numer;
  logic   numer_valid;
  logic   numer_ready;
  rgb_t   rgb;

  hsv2rgb_sector u_sector (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .hue        (s_tdata[8:0]),
    .saturation (s_tdata[16:9]),
    .brightness (s_tdata[24:17]),
    .out_valid  (shade_valid),
    .out_ready  (shade_ready),
    .out_data   (shade)
  );

  hsv2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (shade_valid),
    .in_ready  (shade_ready),
    .in_data   (shade),
    .out_valid (part_valid),
    .out_ready (part_ready),
    .out_data  (part)
  );

  hsv2rgb_mix u_mix (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (part_valid),
    .in_ready  (part_ready),
    .in_data   (part),
    .out_valid (numer_valid),
    .out_ready (numer_ready),
    .out_data  (numer)
  );

  hsv2rgb_divide u_divide (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (numer_valid),
    .in_ready  (numer_ready),
    .in_data   (numer),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (rgb)
  );

  assign m_tdata = {rgb.blue, rgb.green, rgb.red};

  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    (m_tready || !m_tvalid) |-> s_tready)
    else $error("input stalled while output side can drain");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (shade_valid && part_valid && numer_valid && m_tvalid && !m_tready))
    else $error("input stalled with an empty stage");

endmodule

### rtl/hsv2rgb_sector.sv
// Stage one: chroma product, hue ramp and sector decode.
module hsv2rgb_sector
  import hsv2rgb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [8:0] hue,
  input  logic [7:0] saturation,
  input  logic [7:0] brightness,
  output logic       out_valid,
  input  logic       out_ready,
  output shade_t     out_data
);

  logic [8:0]  hue_mod;
  logic [6:0]  r120;
  logic [6:0]  hue_dev;
  logic [6:0]  ramp_w;
  sector_t     sector_w;
  logic [15:0] chroma_w;
  logic [15:0] vscale_w;

  always_comb begin
    priority if (hue < 9'd120) begin
      hue_mod = hue;
    end else if (hue < 9'd240) begin
      hue_mod = hue - 9'd120;
    end else if (hue < 9'd360) begin
      hue_mod = hue - 9'd240;
    end else if (hue < 9'd480) begin
      hue_mod = hue - 9'd360;
    end else begin
      hue_mod = hue - 9'd480;
    end
    r120    = hue_mod[6:0];
    hue_dev = (r120 >= SECTOR_DEG) ? (r120 - SECTOR_DEG) : (SECTOR_DEG - r120);
    ramp_w  = SECTOR_DEG - hue_dev;

    priority if (hue < 9'd60) begin
      sector_w = SEC_RED_YEL;
    end else if (hue < 9'd120) begin
      sector_w = SEC_YEL_GRN;
    end else if (hue < 9'd180) begin
      sector_w = SEC_GRN_CYN;
    end else if (hue < 9'd240) begin
      sector_w = SEC_CYN_BLU;
    end else if (hue < 9'd300) begin
      sector_w = SEC_BLU_MAG;
    end else begin
      sector_w = SEC_MAG_RED;
    end

    chroma_w = {8'b0, saturation} * {8'b0, brightness};
    vscale_w = {brightness, 8'b0} - {8'b0, brightness};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.chroma <= chroma_w;
      out_data.vscale <= vscale_w;
      out_data.ramp   <= ramp_w[5:0];
      out_data.sector <= sector_w;
    end
  end

endmodule

### rtl/hsv2rgb_scale.sv
// Stage two: scale chroma, ramp and offset into numerators over 15300.
module hsv2rgb_scale
  import hsv2rgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  shade_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output part_t  out_data
);

  logic [15:0]      base;
  logic [NUM_W-1:0] pc_w;
  logic [NUM_W-1:0] px_w;
  logic [NUM_W-1:0] off_w;

  always_comb begin
    base  = in_data.vscale - in_data.chroma;
    pc_w  = {6'b0, in_data.chroma} * 22'd60;
    px_w  = {6'b0, in_data.chroma} * {16'b0, in_data.ramp};
    off_w = {6'b0, base} * 22'd60;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.pc     <= pc_w;
      out_data.px     <= px_w;
      out_data.off    <= off_w;
      out_data.sector <= in_data.sector;
    end
  end

endmodule

### rtl/hsv2rgb_mix.sv
// Stage three: add the offset and route parts to channels by sector.
module hsv2rgb_mix
  import hsv2rgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  part_t  in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output numer_t out_data
);

  logic [NUM_W:0] sum_c;
  logic [NUM_W:0] sum_x;
  logic [NUM_W:0] sum_0;
  numer_t         mix_w;

  always_comb begin
    sum_c = {1'b0, in_data.pc} + {1'b0, in_data.off};
    sum_x = {1'b0, in_data.px} + {1'b0, in_data.off};
    sum_0 = {1'b0, in_data.off};
    unique case (in_data.sector)
      SEC_RED_YEL: begin
        mix_w.nr = sum_c[NUM_W-1:0];
        mix_w.ng = sum_x[NUM_W-1:0];
        mix_w.nb = sum_0[NUM_W-1:0];
      end
      SEC_YEL_GRN: begin
        mix_w.nr = sum_x[NUM_W-1:0];
        mix_w.ng = sum_c[NUM_W-1:0];
        mix_w.nb = sum_0[NUM_W-1:0];
      end
      SEC_GRN_CYN: begin
        mix_w.nr = sum_0[NUM_W-1:0];
        mix_w.ng = sum_c[NUM_W-1:0];
        mix_w.nb = sum_x[NUM_W-1:0];
      end
      SEC_CYN_BLU: begin
        mix_w.nr = sum_0[NUM_W-1:0];
        mix_w.ng = sum_x[NUM_W-1:0];
        mix_w.nb = sum_c[NUM_W-1:0];
      end
      SEC_BLU_MAG: begin
        mix_w.nr = sum_x[NUM_W-1:0];
        mix_w.ng = sum_0[NUM_W-1:0];
        mix_w.nb = sum_c[NUM_W-1:0];
      end
      SEC_MAG_RED: begin
        mix_w.nr = sum_c[NUM_W-1:0];
        mix_w.ng = sum_0[NUM_W-1:0];
        mix_w.nb = sum_x[NUM_W-1:0];
      end
      default: begin
        mix_w.nr = '0;
        mix_w.ng = '0;
        mix_w.nb = '0;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data <= mix_w;
    end
  end

  a_sum_fits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> (!sum_c[NUM_W] && !sum_x[NUM_W]))
    else $error("channel numerator overflow");

endmodule

### rtl/hsv2rgb_divide.sv
// Stage four: divide each numerator by 15300 through a reciprocal multiply.
module hsv2rgb_divide
  import hsv2rgb_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  numer_t in_data,
  output logic   out_valid,
  input  logic   out_ready,
  output rgb_t   out_data
);

  logic [PROD_W-1:0] prod_r;
  logic [PROD_W-1:0] prod_g;
  logic [PROD_W-1:0] prod_b;

  always_comb begin
    prod_r = {{RECIP_W{1'b0}}, in_data.nr} * {{NUM_W{1'b0}}, RECIP};
    prod_g = {{RECIP_W{1'b0}}, in_data.ng} * {{NUM_W{1'b0}}, RECIP};
    prod_b = {{RECIP_W{1'b0}}, in_data.nb} * {{NUM_W{1'b0}}, RECIP};
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_data.red   <= prod_r[RECIP_SHIFT +: 8];
      out_data.green <= prod_g[RECIP_SHIFT +: 8];
      out_data.blue  <= prod_b[RECIP_SHIFT +: 8];
    end
  end

  a_quot_fits: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |->
      (!prod_r[PROD_W-1] && !prod_g[PROD_W-1] && !prod_b[PROD_W-1]))
    else $error("channel quotient exceeds eight bits");

endmodule

### test/testbench.sv
// Self-checking stream testbench for the HSV to RGB pixel converter.
`timescale 1ns / 100ps

module testbench
  import hsv2rgb_pkg::*;
();

  typedef struct {
    logic [8:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
    int         gap;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // hue[8:0], saturation[16:9], brightness[24:17], zero[31:25]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;       // red[7:0], green[15:8], blue[23:16]

  pixel_t pixel_queue[$];
  rgb_t   rgb_queue[$];
  int     errors = 0;
  int     hold_cnt = 0;
  int     results_seen = 0;
  int     stall_left = 0;
  int     freeze_left = 0;
  bit     freeze_done = 1'b0;

  hsv_to_rgb_convert u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic rgb_t hsv_to_rgb(logic [8:0] hue, logic [7:0] sat, logic [7:0] val);
    logic [15:0] chroma;
    logic [6:0]  hmod;
    logic [6:0]  hue_dev;
    logic [6:0]  ramp;
    logic [21:0] pc;
    logic [21:0] px;
    logic [21:0] off;
    logic [21:0] pr;
    logic [21:0] pg;
    logic [21:0] pb;
    sector_t     sector;
    rgb_t        res;
    chroma  = 16'(sat) * 16'(val);
    hmod    = 7'(hue % 9'd120);
    hue_dev = (hmod >= 7'd60) ? hmod - 7'd60 : 7'd60 - hmod;
    ramp    = 7'd60 - hue_dev;
    pc      = 22'(chroma) * 22'd60;
    px      = 22'(chroma) * 22'(ramp);
    off     = (22'(val) * 22'd255 - 22'(chroma)) * 22'd60;
    if (hue < 9'd60) sector = SEC_RED_YEL;
    else if (hue < 9'd120) sector = SEC_YEL_GRN;
    else if (hue < 9'd180) sector = SEC_GRN_CYN;
    else if (hue < 9'd240) sector = SEC_CYN_BLU;
    else if (hue < 9'd300) sector = SEC_BLU_MAG;
    else sector = SEC_MAG_RED;
    case (sector)
      SEC_RED_YEL: begin pr = pc; pg = px; pb = '0; end
      SEC_YEL_GRN: begin pr = px; pg = pc; pb = '0; end
      SEC_GRN_CYN: begin pr = '0; pg = pc; pb = px; end
      SEC_CYN_BLU: begin pr = '0; pg = px; pb = pc; end
      SEC_BLU_MAG: begin pr = px; pg = '0; pb = pc; end
      default:     begin pr = pc; pg = '0; pb = px; end
    endcase
    res.red   = 8'((pr + off) / 22'd15300);
    res.green = 8'((pg + off) / 22'd15300);
    res.blue  = 8'((pb + off) / 22'd15300);
    return res;
  endfunction

  task automatic report(string msg);
    errors++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic add_pixel(int hue, int sat, int val, int gap);
    pixel_t p;
    p.hue = 9'(hue);
    p.sat = 8'(sat);
    p.val = 8'(val);
    p.gap = gap;
    pixel_queue.push_back(p);
  endtask

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      hold_cnt <= 0;
    end else begin
      if (s_tvalid && s_tready)
        rgb_queue.push_back(hsv_to_rgb(s_tdata[8:0], s_tdata[16:9], s_tdata[24:17]));
      if (!s_tvalid || s_tready) begin
        if (pixel_queue.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (hold_cnt < pixel_queue[0].gap) begin
          s_tvalid <= 1'b0;
          hold_cnt <= hold_cnt + 1;
        end else begin
          s_tdata  <= {7'b0, pixel_queue[0].val, pixel_queue[0].sat, pixel_queue[0].hue};
          s_tvalid <= 1'b1;
          hold_cnt <= 0;
          pixel_queue.pop_front();
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    rgb_t want;
    if (rst) begin
      m_tready <= 1'b0;
      stall_left = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (rgb_queue.size() == 0) begin
          report($sformatf("unexpected beat %h", m_tdata));
        end else begin
          want = rgb_queue.pop_front();
          if (m_tdata[7:0] !== want.red)
            report($sformatf("red %h, want %h", m_tdata[7:0], want.red));
          if (m_tdata[15:8] !== want.green)
            report($sformatf("green %h, want %h", m_tdata[15:8], want.green));
          if (m_tdata[23:16] !== want.blue)
            report($sformatf("blue %h, want %h", m_tdata[23:16], want.blue));
        end
        results_seen <= results_seen + 1;
        stall_left = ((results_seen % 150) < 40) ? 0 : $urandom_range(0, 10);
      end else if (stall_left > 0) begin
        stall_left = stall_left - 1;
      end
      m_tready <= (stall_left == 0) && (freeze_left == 0);
    end
  end

  // long receiver hold-off
  always @(posedge clk) begin
    if (rst) begin
      freeze_left <= 0;
      freeze_done <= 1'b0;
    end else if (!freeze_done && results_seen >= 120) begin
      freeze_left <= 80;
      freeze_done <= 1'b1;
    end else if (freeze_left > 0) begin
      freeze_left <= freeze_left - 1;
    end
  end

  initial begin
    int hue;
    int gap;
    // sector borders at full saturation and brightness
    add_pixel(0, 255, 255, 0);
    add_pixel(59, 255, 255, 0);
    add_pixel(60, 255, 255, 1);
    add_pixel(119, 255, 255, 0);
    add_pixel(120, 255, 255, 0);
    add_pixel(179, 255, 255, 2);
    add_pixel(180, 255, 255, 0);
    add_pixel(239, 255, 255, 0);
    add_pixel(240, 255, 255, 0);
    add_pixel(299, 255, 255, 3);
    add_pixel(300, 255, 255, 0);
    add_pixel(359, 255, 255, 0);
    // hue past the circle
    add_pixel(360, 255, 255, 0);
    add_pixel(511, 200, 180, 0);
    add_pixel(420, 90, 255, 1);
    // grey, black, white, a mid colour, and saturation or brightness of one
    add_pixel(200, 0, 128, 0);
    add_pixel(45, 255, 0, 0);
    add_pixel(0, 0, 0, 0);
    add_pixel(330, 0, 255, 0);
    add_pixel(30, 128, 200, 0);
    add_pixel(150, 1, 1, 0);
    add_pixel(270, 255, 1, 0);
    add_pixel(90, 1, 255, 0);
    for (int i = 0; i < 450; i++) begin
      if ($urandom_range(0, 9) == 0) hue = $urandom_range(360, 511);
      else hue = $urandom_range(0, 359);
      if ((i >= 100 && i < 260) || ((i / 60) % 3 == 2)) gap = 0;
      else gap = $urandom_range(0, 10);
      case ($urandom_range(0, 7))
        0:       add_pixel(hue, 255, $urandom_range(0, 255), gap);
        1:       add_pixel(hue, $urandom_range(0, 255), 255, gap);
        2:       add_pixel(hue, $urandom_range(0, 3), $urandom_range(0, 255), gap);
        default: add_pixel(hue, $urandom_range(0, 255), $urandom_range(0, 255), gap);
      endcase
    end
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    while (pixel_queue.size() != 0 || s_tvalid || rgb_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (rgb_queue.size() != 0) report("pixels without result");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
